FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the range product block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, silent while reset is high.
`define RPMC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds through reset.
`define RPMC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/rpmc_pkg.sv
// ---------------------------------------------------------------------------
// rpmc_pkg
// Widths, command codes, defaults and unit handshake types.
// ---------------------------------------------------------------------------
package rpmc_pkg;

   localparam int VAL_W  = 30;
   localparam int EXP_W  = 17;
   localparam int IDX_W  = 12;
   localparam int CMD_W  = 2;
   localparam int STEP_W = $clog2(VAL_W);

   localparam int DEF_MAX_ELEMENTS = 4096;
   localparam int DEF_MAX_PRIMES   = 10;
   localparam int DEF_TRIAL_LIMIT  = 50000;

   localparam logic [VAL_W-1:0] MOD_RESET = VAL_W'(2);

   localparam logic [CMD_W-1:0] CMD_START = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

   typedef struct packed {
      logic             go;
      logic [VAL_W-1:0] num;
      logic [VAL_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [VAL_W-1:0] quo;
      logic [VAL_W-1:0] rem;
   } div_rsp_type;

   typedef struct packed {
      logic             go;
      logic [VAL_W-1:0] a;
      logic [VAL_W-1:0] b;
      logic [VAL_W-1:0] m;
   } mul_req_type;

   typedef struct packed {
      logic             done;
      logic [VAL_W-1:0] prod;
   } mul_rsp_type;

endpackage

FILE: rtl/rpmc_req_if.sv
// ---------------------------------------------------------------------------
// rpmc_req_if
// Command channel: valid/ready with the command payload.
// ---------------------------------------------------------------------------
interface rpmc_req_if import rpmc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CMD_W-1:0] cmd;
   logic [VAL_W-1:0] element_value;
   logic [IDX_W-1:0] first_index;
   logic [IDX_W-1:0] second_index;

   modport source (output valid, cmd, element_value, first_index, second_index,
                   input ready);
   modport sink   (input valid, cmd, element_value, first_index, second_index,
                   output ready);
endinterface

FILE: rtl/rpmc_rsp_if.sv
// ---------------------------------------------------------------------------
// rpmc_rsp_if
// Result channel: valid/ready with the range product and error code.
// ---------------------------------------------------------------------------
interface rpmc_rsp_if import rpmc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [VAL_W-1:0] range_product;
   logic             error_code;

   modport source (output valid, range_product, error_code, input ready);
   modport sink   (input valid, range_product, error_code, output ready);
endinterface

FILE: rtl/rpmc_div.sv
// ---------------------------------------------------------------------------
// rpmc_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module rpmc_div import rpmc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [VAL_W-1:0]  quo_ff, quo_in;
   logic [VAL_W-1:0]  rem_ff, rem_in;
   logic [VAL_W-1:0]  den_ff, den_in;
   logic [VAL_W:0]    trial;
   logic [VAL_W:0]    diff;
   logic              fits;

   assign trial = {rem_ff, quo_ff[VAL_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (req.go) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = req.num;
         rem_in  = '0;
         den_in  = req.den;
      end else if (busy_ff) begin
         rem_in = fits ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
         quo_in = {quo_ff[VAL_W-2:0], fits};
         cnt_in = cnt_ff + STEP_W'(1);
         if (cnt_ff == STEP_W'(VAL_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;
   assign rsp.rem  = rem_ff;
endmodule

FILE: rtl/rpmc_modmul.sv
// ---------------------------------------------------------------------------
// rpmc_modmul
// Modular multiplier, double-and-add over one multiplier bit per cycle.
// ---------------------------------------------------------------------------
module rpmc_modmul import rpmc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type req,
   output mul_rsp_type rsp
);
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [VAL_W-1:0]  a_ff, a_in;
   logic [VAL_W-1:0]  b_ff, b_in;
   logic [VAL_W-1:0]  m_ff, m_in;
   logic [VAL_W-1:0]  acc_ff, acc_in;
   logic [VAL_W:0]    dbl;
   logic [VAL_W:0]    dbl_red;
   logic [VAL_W:0]    sum;
   logic [VAL_W:0]    sum_red;

   // operands stay below the modulus, so one conditional subtract per add
   assign dbl     = {acc_ff, 1'b0};
   assign dbl_red = (dbl >= {1'b0, m_ff}) ? dbl - {1'b0, m_ff} : dbl;
   assign sum     = dbl_red + (a_ff[VAL_W-1] ? {1'b0, b_ff} : '0);
   assign sum_red = (sum >= {1'b0, m_ff}) ? sum - {1'b0, m_ff} : sum;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      m_in    = m_ff;
      acc_in  = acc_ff;
      if (req.go) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         a_in    = req.a;
         b_in    = req.b;
         m_in    = req.m;
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in = sum_red[VAL_W-1:0];
         a_in   = {a_ff[VAL_W-2:0], 1'b0};
         cnt_in = cnt_ff + STEP_W'(1);
         if (cnt_ff == STEP_W'(VAL_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      m_ff   <= m_in;
      acc_ff <= acc_in;
   end

   assign rsp.done = done_ff;
   assign rsp.prod = acc_ff;
endmodule

FILE: rtl/range_product_modulo_composite.sv
// ---------------------------------------------------------------------------
// range_product_modulo_composite
// Range product modulo a composite modulus, built on a shared divider and a
// shared modular multiplier under one sequencer.
// ---------------------------------------------------------------------------
// Every division and modular multiplication goes through one of two
// bit-serial units: a restoring divider and a double-and-add modular
// multiplier. Item latency therefore scales with the number of unit
// operations, and the block takes no new command until the current one is
// finished:
//   start : one division per trial divisor up to min(TRIAL_LIMIT,
//           sqrt(cofactor)), plus exponent + 1 divisions per prime found;
//   load  : up to primes + sum of exponents + 2 unit operations for
//           factoring, then bits + set bits of totient - 1 for the inverse;
//   query : per prime bits + set bits of its exponent + 1 multiplies, plus
//           up to 2 for the coprime part; an out-of-range index uses none.
// Responses sit in an output register, so the next command is taken while
// a result waits. The modulus register is sampled at start only.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module range_product_modulo_composite import rpmc_pkg::*; #(
   parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
   parameter int MAX_PRIMES   = DEF_MAX_PRIMES,
   parameter int TRIAL_LIMIT  = DEF_TRIAL_LIMIT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_enable,
   input  logic [VAL_W-1:0] csr_write_data,
   rpmc_req_if.sink         req_bus,
   rpmc_rsp_if.source       rsp_bus
);
   localparam int LC_W   = $clog2(MAX_ELEMENTS + 1);
   localparam int EI_W   = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int PC_W   = $clog2(MAX_PRIMES + 1);
   localparam int PI_W   = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;
   localparam int EXP_DEPTH = MAX_PRIMES * MAX_ELEMENTS;
   localparam int EA_W   = (EXP_DEPTH > 1) ? $clog2(EXP_DEPTH) : 1;
   localparam int CAND_W = $clog2(TRIAL_LIMIT + 2);
   localparam int SQ_W   = 2 * CAND_W;
   localparam int CMP_W  = (IDX_W > LC_W) ? IDX_W : LC_W;

   // sequencer states
   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_TCHK   = 5'd1;
   localparam logic [4:0] S_TWAIT  = 5'd2;
   localparam logic [4:0] S_TTOT   = 5'd3;
   localparam logic [4:0] S_TSTRIP = 5'd4;
   localparam logic [4:0] S_TAIL   = 5'd5;
   localparam logic [4:0] S_TAILW  = 5'd6;
   localparam logic [4:0] S_LK     = 5'd7;
   localparam logic [4:0] S_LDIV   = 5'd8;
   localparam logic [4:0] S_LPARTW = 5'd9;
   localparam logic [4:0] S_LMUL   = 5'd10;
   localparam logic [4:0] S_LINV   = 5'd11;
   localparam logic [4:0] S_POW    = 5'd12;
   localparam logic [4:0] S_POWA   = 5'd13;
   localparam logic [4:0] S_POWS   = 5'd14;
   localparam logic [4:0] S_QK     = 5'd15;
   localparam logic [4:0] S_QRD1   = 5'd16;
   localparam logic [4:0] S_QRD2   = 5'd17;
   localparam logic [4:0] S_QMUL   = 5'd18;
   localparam logic [4:0] S_QCP1   = 5'd19;
   localparam logic [4:0] S_QCP2   = 5'd20;
   localparam logic [4:0] S_QINV1  = 5'd21;
   localparam logic [4:0] S_QINV2  = 5'd22;
   localparam logic [4:0] S_FIN    = 5'd23;

   // control and configuration
   logic [4:0]       state_ff, state_in;
   logic [VAL_W-1:0] mod_ff, mod_in;
   logic [VAL_W-1:0] amod_ff, amod_in;
   logic             started_ff, started_in;
   logic [VAL_W-1:0] prime_ff [MAX_PRIMES];
   logic [VAL_W-1:0] prime_in [MAX_PRIMES];
   logic [PC_W-1:0]  pcount_ff, pcount_in;
   logic [VAL_W-1:0] tot_ff, tot_in;
   logic [LC_W-1:0]  lcount_ff, lcount_in;

   // working registers
   logic [VAL_W-1:0]  work_ff, work_in;
   logic [CAND_W-1:0] cand_ff, cand_in;
   logic [SQ_W-1:0]   sq_ff, sq_in;
   logic [PC_W-1:0]   k_ff, k_in;
   logic [EXP_W-1:0]  cnt_ff, cnt_in;
   logic [EXP_W-1:0]  ehi_ff, ehi_in;
   logic [VAL_W-1:0]  base_ff, base_in;
   logic [VAL_W-1:0]  pacc_ff, pacc_in;
   logic [VAL_W-1:0]  pexp_ff, pexp_in;
   logic              pret_ff, pret_in;
   logic [VAL_W-1:0]  qacc_ff, qacc_in;
   logic              qerr_ff, qerr_in;
   logic [EI_W-1:0]   hi_ff, hi_in;
   logic [EI_W-1:0]   lo_ff, lo_in;
   logic              lonz_ff, lonz_in;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0] rsp_prod_ff, rsp_prod_in;
   logic             rsp_err_ff, rsp_err_in;

   // shared units
   div_req_type div_req_ff, div_req_in;
   div_rsp_type div_rsp;
   mul_req_type mul_req_ff, mul_req_in;
   mul_rsp_type mul_rsp;

   // memories
   logic [EXP_W-1:0] exp_mem [EXP_DEPTH];
   logic [VAL_W-1:0] cop_mem [MAX_ELEMENTS];
   logic [VAL_W-1:0] inv_mem [MAX_ELEMENTS];
   logic [EXP_W-1:0] exp_rd_ff;
   logic [VAL_W-1:0] cop_rd_ff;
   logic [VAL_W-1:0] inv_rd_ff;
   logic             exp_we, exp_re, cop_we, cop_re, inv_we, inv_re;
   logic [EA_W-1:0]  exp_waddr, exp_raddr;
   logic [EXP_W-1:0] exp_wdata;
   logic [EI_W-1:0]  cop_waddr, cop_raddr, inv_waddr, inv_raddr;
   logic [VAL_W-1:0] cop_wdata, inv_wdata;

   // helpers
   logic [PI_W-1:0]  kidx, pidx;
   logic [VAL_W-1:0] prime_k;
   logic [EI_W-1:0]  lidx;
   logic             lnz;
   logic             can_rec;
   logic [SQ_W-1:0]  sq_step;
   logic [IDX_W-1:0] lo_raw, hi_raw;
   logic [CMP_W-1:0] hi_c, lc_c;
   logic [EXP_W-1:0] ediff;
   logic             accept;

   function automatic logic [EA_W-1:0] exp_addr(input logic [PI_W-1:0] kk,
                                                input logic [EI_W-1:0] ii);
      return EA_W'(kk) * EA_W'(MAX_ELEMENTS) + EA_W'(ii);
   endfunction

   assign kidx    = k_ff[PI_W-1:0];
   assign pidx    = pcount_ff[PI_W-1:0];
   assign prime_k = prime_ff[kidx];
   assign lidx    = lcount_ff[EI_W-1:0];
   assign lnz     = lcount_ff != '0;
   assign can_rec = pcount_ff < PC_W'(MAX_PRIMES);
   assign sq_step = sq_ff + SQ_W'({cand_ff, 1'b0}) + SQ_W'(1);
   assign lo_raw  = (req_bus.first_index < req_bus.second_index) ?
                    req_bus.first_index : req_bus.second_index;
   assign hi_raw  = (req_bus.first_index < req_bus.second_index) ?
                    req_bus.second_index : req_bus.first_index;
   assign hi_c    = CMP_W'(hi_raw);
   assign lc_c    = CMP_W'(lcount_ff);
   // counts wrap, so the range difference stays at count width
   assign ediff   = ehi_ff - exp_rd_ff;
   assign accept  = req_bus.valid && req_bus.ready;

   assign req_bus.ready         = state_ff == S_IDLE;
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.range_product = rsp_prod_ff;
   assign rsp_bus.error_code    = rsp_err_ff;

   rpmc_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req_ff),
      .rsp   (div_rsp)
   );

   rpmc_modmul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req_ff),
      .rsp   (mul_rsp)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      mod_in       = csr_write_enable ? csr_write_data : mod_ff;
      amod_in      = amod_ff;
      started_in   = started_ff;
      prime_in     = prime_ff;
      pcount_in    = pcount_ff;
      tot_in       = tot_ff;
      lcount_in    = lcount_ff;
      work_in      = work_ff;
      cand_in      = cand_ff;
      sq_in        = sq_ff;
      k_in         = k_ff;
      cnt_in       = cnt_ff;
      ehi_in       = ehi_ff;
      base_in      = base_ff;
      pacc_in      = pacc_ff;
      pexp_in      = pexp_ff;
      pret_in      = pret_ff;
      qacc_in      = qacc_ff;
      qerr_in      = qerr_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      lonz_in      = lonz_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_prod_in  = rsp_prod_ff;
      rsp_err_in   = rsp_err_ff;
      div_req_in   = div_req_ff;
      div_req_in.go = 1'b0;
      mul_req_in   = mul_req_ff;
      mul_req_in.go = 1'b0;
      mul_req_in.m = amod_ff;
      exp_we    = 1'b0;
      exp_re    = 1'b0;
      exp_waddr = exp_addr(kidx, lidx);
      exp_raddr = exp_addr(kidx, lidx - EI_W'(1));
      exp_wdata = (lnz ? exp_rd_ff : '0) + cnt_ff;
      cop_we    = 1'b0;
      cop_re    = 1'b0;
      cop_waddr = lidx;
      cop_raddr = lidx - EI_W'(1);
      cop_wdata = base_ff;
      inv_we    = 1'b0;
      inv_re    = 1'b0;
      inv_waddr = lidx;
      inv_raddr = lo_ff - EI_W'(1);
      inv_wdata = pacc_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_bus.cmd)
                  CMD_START: begin
                     amod_in    = (mod_ff < VAL_W'(2)) ? VAL_W'(2) : mod_ff;
                     work_in    = amod_in;
                     tot_in     = amod_in;
                     pcount_in  = '0;
                     for (int i = 0; i < MAX_PRIMES; i++) begin
                        prime_in[i] = '0;
                     end
                     cand_in    = CAND_W'(2);
                     sq_in      = SQ_W'(4);
                     lcount_in  = '0;
                     started_in = 1'b1;
                     state_in   = S_TCHK;
                  end
                  CMD_LOAD: begin
                     // drop loads before start, zero elements and a full list
                     if (started_ff && req_bus.element_value != '0 &&
                         lcount_ff < LC_W'(MAX_ELEMENTS)) begin
                        work_in  = req_bus.element_value;
                        k_in     = '0;
                        state_in = S_LK;
                     end
                  end
                  CMD_QUERY: begin
                     hi_in   = EI_W'(hi_c);
                     lo_in   = EI_W'(lo_raw);
                     lonz_in = lo_raw != '0;
                     k_in    = '0;
                     if (hi_c >= lc_c) begin
                        qacc_in = '0;
                        qerr_in = 1'b1;
                        state_in = S_FIN;
                     end else begin
                        qacc_in = VAL_W'(1);
                        qerr_in = 1'b0;
                        state_in = S_QK;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         // trial division of the modulus
         S_TCHK: begin
            if (cand_ff <= CAND_W'(TRIAL_LIMIT) && sq_ff <= SQ_W'(work_ff)) begin
               div_req_in = '{go: 1'b1, num: work_ff, den: VAL_W'(cand_ff)};
               state_in   = S_TWAIT;
            end else begin
               state_in = S_TAIL;
            end
         end
         S_TWAIT: begin
            if (div_rsp.done) begin
               if (div_rsp.rem == '0) begin
                  work_in = div_rsp.quo;
                  if (can_rec) begin
                     prime_in[pidx] = VAL_W'(cand_ff);
                     pcount_in      = pcount_ff + PC_W'(1);
                  end
                  div_req_in = '{go: 1'b1, num: tot_ff, den: VAL_W'(cand_ff)};
                  state_in   = S_TTOT;
               end else begin
                  cand_in  = cand_ff + CAND_W'(1);
                  sq_in    = sq_step;
                  state_in = S_TCHK;
               end
            end
         end
         S_TTOT: begin
            if (div_rsp.done) begin
               tot_in     = tot_ff - div_rsp.quo;
               div_req_in = '{go: 1'b1, num: work_ff, den: VAL_W'(cand_ff)};
               state_in   = S_TSTRIP;
            end
         end
         S_TSTRIP: begin
            // strip every power of the prime just found
            if (div_rsp.done) begin
               if (div_rsp.rem == '0) begin
                  work_in    = div_rsp.quo;
                  div_req_in = '{go: 1'b1, num: div_rsp.quo, den: VAL_W'(cand_ff)};
               end else begin
                  cand_in  = cand_ff + CAND_W'(1);
                  sq_in    = sq_step;
                  state_in = S_TCHK;
               end
            end
         end
         S_TAIL: begin
            // leftover cofactor above one is a prime
            if (work_ff > VAL_W'(1)) begin
               if (can_rec) begin
                  prime_in[pidx] = work_ff;
                  pcount_in      = pcount_ff + PC_W'(1);
               end
               div_req_in = '{go: 1'b1, num: tot_ff, den: work_ff};
               state_in   = S_TAILW;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_TAILW: begin
            if (div_rsp.done) begin
               tot_in   = tot_ff - div_rsp.quo;
               state_in = S_IDLE;
            end
         end

         // load: exponent per prime, then coprime prefix and its inverse
         S_LK: begin
            if (k_ff < pcount_ff) begin
               cnt_in     = '0;
               exp_re     = lnz;
               div_req_in = '{go: 1'b1, num: work_ff, den: prime_k};
               state_in   = S_LDIV;
            end else begin
               cop_re     = lnz;
               div_req_in = '{go: 1'b1, num: work_ff, den: amod_ff};
               state_in   = S_LPARTW;
            end
         end
         S_LDIV: begin
            if (div_rsp.done) begin
               if (div_rsp.rem == '0) begin
                  work_in    = div_rsp.quo;
                  cnt_in     = cnt_ff + EXP_W'(1);
                  div_req_in = '{go: 1'b1, num: div_rsp.quo, den: prime_k};
               end else begin
                  exp_we   = 1'b1;
                  k_in     = k_ff + PC_W'(1);
                  state_in = S_LK;
               end
            end
         end
         S_LPARTW: begin
            if (div_rsp.done) begin
               if (lnz) begin
                  mul_req_in.go = 1'b1;
                  mul_req_in.a  = cop_rd_ff;
                  mul_req_in.b  = div_rsp.rem;
                  state_in      = S_LMUL;
               end else begin
                  base_in  = div_rsp.rem;
                  state_in = S_LINV;
               end
            end
         end
         S_LMUL: begin
            if (mul_rsp.done) begin
               base_in  = mul_rsp.prod;
               state_in = S_LINV;
            end
         end
         S_LINV: begin
            cop_we   = 1'b1;
            pacc_in  = VAL_W'(1);
            pexp_in  = tot_ff - VAL_W'(1);
            pret_in  = 1'b0;
            state_in = S_POW;
         end

         // square-and-multiply, shared by load and query
         S_POW: begin
            if (pexp_ff == '0) begin
               if (pret_ff) begin
                  mul_req_in.go = 1'b1;
                  mul_req_in.a  = qacc_ff;
                  mul_req_in.b  = pacc_ff;
                  state_in      = S_QMUL;
               end else begin
                  inv_we    = 1'b1;
                  lcount_in = lcount_ff + LC_W'(1);
                  state_in  = S_IDLE;
               end
            end else if (pexp_ff[0]) begin
               mul_req_in.go = 1'b1;
               mul_req_in.a  = pacc_ff;
               mul_req_in.b  = base_ff;
               state_in      = S_POWA;
            end else begin
               mul_req_in.go = 1'b1;
               mul_req_in.a  = base_ff;
               mul_req_in.b  = base_ff;
               state_in      = S_POWS;
            end
         end
         S_POWA: begin
            if (mul_rsp.done) begin
               pacc_in       = mul_rsp.prod;
               mul_req_in.go = 1'b1;
               mul_req_in.a  = base_ff;
               mul_req_in.b  = base_ff;
               state_in      = S_POWS;
            end
         end
         S_POWS: begin
            if (mul_rsp.done) begin
               base_in  = mul_rsp.prod;
               pexp_in  = {1'b0, pexp_ff[VAL_W-1:1]};
               state_in = S_POW;
            end
         end

         // query: prime powers over the range, then the coprime part
         S_QK: begin
            if (k_ff < pcount_ff) begin
               exp_re    = 1'b1;
               exp_raddr = exp_addr(kidx, hi_ff);
               state_in  = S_QRD1;
            end else begin
               cop_re    = 1'b1;
               cop_raddr = hi_ff;
               state_in  = S_QCP1;
            end
         end
         S_QRD1: begin
            ehi_in    = exp_rd_ff;
            exp_re    = lonz_ff;
            exp_raddr = exp_addr(kidx, lo_ff - EI_W'(1));
            state_in  = S_QRD2;
         end
         S_QRD2: begin
            pexp_in  = VAL_W'(lonz_ff ? ediff : ehi_ff);
            base_in  = (prime_k == amod_ff) ? '0 : prime_k;
            pacc_in  = VAL_W'(1);
            pret_in  = 1'b1;
            state_in = S_POW;
         end
         S_QMUL: begin
            if (mul_rsp.done) begin
               qacc_in  = mul_rsp.prod;
               k_in     = k_ff + PC_W'(1);
               state_in = S_QK;
            end
         end
         S_QCP1: begin
            mul_req_in.go = 1'b1;
            mul_req_in.a  = qacc_ff;
            mul_req_in.b  = cop_rd_ff;
            state_in      = S_QCP2;
         end
         S_QCP2: begin
            if (mul_rsp.done) begin
               qacc_in = mul_rsp.prod;
               if (lonz_ff) begin
                  inv_re   = 1'b1;
                  state_in = S_QINV1;
               end else begin
                  state_in = S_FIN;
               end
            end
         end
         S_QINV1: begin
            mul_req_in.go = 1'b1;
            mul_req_in.a  = qacc_ff;
            mul_req_in.b  = inv_rd_ff;
            state_in      = S_QINV2;
         end
         S_QINV2: begin
            if (mul_rsp.done) begin
               qacc_in  = mul_rsp.prod;
               state_in = S_FIN;
            end
         end

         // hold until the output register is free
         S_FIN: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_prod_in  = qacc_ff;
               rsp_err_in   = qerr_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         mod_ff        <= MOD_RESET;
         amod_ff       <= '0;
         started_ff    <= 1'b0;
         pcount_ff     <= '0;
         tot_ff        <= '0;
         lcount_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
         div_req_ff.go <= 1'b0;
         mul_req_ff.go <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mod_ff       <= mod_in;
         amod_ff      <= amod_in;
         started_ff   <= started_in;
         pcount_ff    <= pcount_in;
         tot_ff       <= tot_in;
         lcount_ff    <= lcount_in;
         rsp_valid_ff <= rsp_valid_in;
         div_req_ff   <= div_req_in;
         mul_req_ff   <= mul_req_in;
      end
      prime_ff    <= prime_in;
      work_ff     <= work_in;
      cand_ff     <= cand_in;
      sq_ff       <= sq_in;
      k_ff        <= k_in;
      cnt_ff      <= cnt_in;
      ehi_ff      <= ehi_in;
      base_ff     <= base_in;
      pacc_ff     <= pacc_in;
      pexp_ff     <= pexp_in;
      pret_ff     <= pret_in;
      qacc_ff     <= qacc_in;
      qerr_ff     <= qerr_in;
      hi_ff       <= hi_in;
      lo_ff       <= lo_in;
      lonz_ff     <= lonz_in;
      rsp_prod_ff <= rsp_prod_in;
      rsp_err_ff  <= rsp_err_in;
   end

   // prefix stores: one write and one registered read per cycle each
   always_ff @(posedge clock) begin
      if (exp_we) begin
         exp_mem[exp_waddr] <= exp_wdata;
      end
      if (exp_re) begin
         exp_rd_ff <= exp_mem[exp_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cop_we) begin
         cop_mem[cop_waddr] <= cop_wdata;
      end
      if (cop_re) begin
         cop_rd_ff <= cop_mem[cop_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (inv_we) begin
         inv_mem[inv_waddr] <= inv_wdata;
      end
      if (inv_re) begin
         inv_rd_ff <= inv_mem[inv_raddr];
      end
   end

   `RPMC_ASSERT(a_div_done_waited, clock, reset, div_rsp.done |-> (state_ff == S_TWAIT || state_ff == S_TTOT || state_ff == S_TSTRIP || state_ff == S_TAILW || state_ff == S_LDIV || state_ff == S_LPARTW), "divider result arrived outside a divide wait")
   `RPMC_ASSERT(a_mul_done_waited, clock, reset, mul_rsp.done |-> (state_ff == S_LMUL || state_ff == S_POWA || state_ff == S_POWS || state_ff == S_QMUL || state_ff == S_QCP2 || state_ff == S_QINV2), "multiplier result arrived outside a multiply wait")
   `RPMC_ASSERT(a_err_zero, clock, reset, (rsp_valid_ff && rsp_err_ff) |-> (rsp_prod_ff == '0), "error response carries a nonzero product")
   `RPMC_ASSERT(a_load_one, clock, reset, (lcount_ff != $past(lcount_ff) && $past(lcount_ff) != '0 && lcount_ff != '0) |-> (lcount_ff == $past(lcount_ff) + LC_W'(1) && $past(state_ff) == S_POW), "element count moved other than by one finished load")
   `RPMC_ASSERT(a_counts_bounded, clock, reset, (lcount_ff <= LC_W'(MAX_ELEMENTS)) && (pcount_ff <= PC_W'(MAX_PRIMES)), "element or prime count past its limit")
endmodule
